// File: src/max_heap_delete_root_top_defines.svh
// Assertion macros shared by the heap block.
`ifndef MAX_HEAP_DELETE_ROOT_TOP_DEFINES_SVH
`define MAX_HEAP_DELETE_ROOT_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MHDR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MHDR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/mhdr_pkg.sv
`timescale 1ns / 1ps

package mhdr_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int CHILD_W    = ADDR_W + 2;
  localparam int VALUE_W    = 32;
  localparam int REM_W      = 7;
  localparam int STATUS_W   = 2;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic [ADDR_W-1:0]            addr_t;
  typedef logic [CNT_W-1:0]             count_t;

  typedef enum logic [0:0] {
    REQ_APPEND = 1'b0,
    REQ_DELETE = 1'b1
  } req_type_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

// File: src/mhdr_req_if.sv
`timescale 1ns / 1ps

interface mhdr_req_if import mhdr_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink (input valid, input req_type, input value, output ready);
endinterface

// File: src/mhdr_rsp_if.sv
`timescale 1ns / 1ps

interface mhdr_rsp_if import mhdr_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] removed_value;
  logic [REM_W-1:0]          remaining_count;
  logic [STATUS_W-1:0]       status;

  modport source (output valid, output removed_value, output remaining_count,
                  output status, input ready);
  modport sink (input valid, input removed_value, input remaining_count,
                input status, output ready);
endinterface

// File: src/max_heap_delete_root_top.sv
`timescale 1ns / 1ps
// Binary max-heap of up to 64 signed 32-bit entries kept in a synchronous RAM with
// one write and two read ports. An append writes the word at the end of the heap;
// the caller must load entries in heap order, which the block does not enforce. A
// delete returns the root at once from a cached copy, then pulls the last entry
// and sifts it down: the last entry is fetched first, then the levels are visited
// one after another, since each level waits for the registered RAM read of both
// children. A delete of the only entry needs no sift, like an append, while any
// other delete holds the block through the fetch and the sift. No new word is taken
// until the sift ends. The result word is registered, and a result that still
// waits holds off the input: a new request is taken at the earliest in the cycle
// in which the previous result leaves. Empty deletes and full appends report an
// error and change nothing. There is no clearing pass after reset.

`include "max_heap_delete_root_top_defines.svh"

module max_heap_delete_root_top
  import mhdr_pkg::*;
(
  input logic        clk,
  input logic        rst,
  mhdr_req_if.sink   req,
  mhdr_rsp_if.source rsp
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LAST,
    S_CMP
  } state_t;

  state_t state;
  count_t count;
  addr_t  pos;
  data_t  carry;
  data_t  root_q;

  logic                      out_valid;
  logic signed [VALUE_W-1:0] out_removed;
  logic [REM_W-1:0]          out_count;
  logic [STATUS_W-1:0]       out_status;

  logic  accept;
  logic  ram_we;
  addr_t ram_waddr;
  data_t ram_wdata;
  addr_t ram_raddr0;
  addr_t ram_raddr1;
  logic [DATA_WIDTH-1:0] ram_rdata0;
  logic [DATA_WIDTH-1:0] ram_rdata1;

  logic [CHILD_W-1:0] lc;
  logic [CHILD_W-1:0] rc;
  logic               lc_ok;
  logic               rc_ok;
  logic               move;
  addr_t              best;
  data_t              best_val;
  logic [CHILD_W-1:0] next_lc;

  mhdr_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_WIDTH),
    .AW    (ADDR_W)
  ) u_ram (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .raddr0 (ram_raddr0),
    .raddr1 (ram_raddr1),
    .rdata0 (ram_rdata0),
    .rdata1 (ram_rdata1)
  );

  // Take a word only between sifts and when the result register can be refilled.
  assign req.ready = (state == S_IDLE) && (!out_valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  assign rsp.valid           = out_valid;
  assign rsp.removed_value   = out_removed;
  assign rsp.remaining_count = out_count;
  assign rsp.status          = out_status;

  // Pick the larger child against the carried entry; the left child is tried first
  // and only a strictly larger value displaces the current winner.
  always_comb begin
    lc       = {1'b0, pos, 1'b1};
    rc       = lc + CHILD_W'(1);
    lc_ok    = lc < CHILD_W'(count);
    rc_ok    = rc < CHILD_W'(count);
    move     = 1'b0;
    best     = pos;
    best_val = carry;
    if (lc_ok && (data_t'(ram_rdata0) > best_val)) begin
      move     = 1'b1;
      best     = lc[ADDR_W-1:0];
      best_val = data_t'(ram_rdata0);
    end
    if (rc_ok && (data_t'(ram_rdata1) > best_val)) begin
      move     = 1'b1;
      best     = rc[ADDR_W-1:0];
      best_val = data_t'(ram_rdata1);
    end
    next_lc = {1'b0, best, 1'b1};
  end

  // RAM port control for appends, the last-entry fetch and each sift level.
  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = count[ADDR_W-1:0];
    ram_wdata  = data_t'(req.value);
    ram_raddr0 = '0;
    ram_raddr1 = '0;
    case (state)
      S_IDLE: begin
        if (accept && (req.req_type == REQ_APPEND) && (count != count_t'(CAPACITY))) begin
          ram_we = 1'b1;
        end
        ram_raddr0 = ADDR_W'(count - count_t'(1));
      end
      S_LAST: begin
        ram_raddr0 = addr_t'(1);
        ram_raddr1 = addr_t'(2);
      end
      S_CMP: begin
        ram_we     = 1'b1;
        ram_waddr  = pos;
        ram_wdata  = move ? best_val : carry;
        ram_raddr0 = next_lc[ADDR_W-1:0];
        ram_raddr1 = ADDR_W'(next_lc + CHILD_W'(1));
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Sequencer, heap size, root cache and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            out_removed <= '0;
            out_status  <= ST_OK;
            out_count   <= REM_W'(count);
            if (req.req_type == REQ_APPEND) begin
              if (count == count_t'(CAPACITY)) begin
                out_status <= ST_FULL;
              end else begin
                count     <= count + count_t'(1);
                out_count <= REM_W'(count + count_t'(1));
              end
            end else if (count == '0) begin
              out_status <= ST_EMPTY;
            end else begin
              out_removed <= VALUE_W'(root_q);
              count       <= count - count_t'(1);
              out_count   <= REM_W'(count - count_t'(1));
              if (count != count_t'(1)) begin
                state <= S_LAST;
              end
            end
          end
        end
        S_LAST: begin
          carry <= data_t'(ram_rdata0);
          pos   <= '0;
          state <= S_CMP;
        end
        S_CMP: begin
          if (move) begin
            pos <= best;
          end else begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
    // The root cache follows every write to the top of the heap.
    if (ram_we && (ram_waddr == '0)) begin
      root_q <= ram_wdata;
    end
  end

  `MHDR_ASSERT_SAME(a_count_bound, 1'b1, count <= count_t'(CAPACITY), "heap size past capacity")
  `MHDR_ASSERT_SAME(a_sift_nonempty, state != S_IDLE, count != '0, "sift running on empty heap")
  `MHDR_ASSERT_NEXT(a_delete_count, accept && (req.req_type == REQ_DELETE) && (count != '0), count == $past(count) - count_t'(1), "delete did not shrink heap")
  `MHDR_ASSERT_NEXT(a_root_cache, ram_we && (ram_waddr == '0), root_q == $past(ram_wdata), "root cache missed a write")

endmodule

// File: src/mhdr_ram.sv
`timescale 1ns / 1ps

module mhdr_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr0,
  input  logic [AW-1:0]    raddr1,
  output logic [WIDTH-1:0] rdata0,
  output logic [WIDTH-1:0] rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and two registered read ports.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import mhdr_pkg::*;

  localparam int N_RANDOM  = 1200;
  localparam int PHASE_LEN = 100;
  localparam int HOLD_AT   = 300;
  localparam int HOLD_LEN  = 400;
  localparam int PAUSE_AT  = 800;
  localparam int DRAIN_CYC = 20;

  localparam longint VAL_MAX = 64'sd2147483647;
  localparam longint VAL_MIN = -64'sd2147483648;

  // One request word and one response word as the heap sees them.
  typedef struct packed {
    req_type_t                 op;
    logic signed [VALUE_W-1:0] val;
  } heap_req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] removed;
    logic [REM_W-1:0]          count;
    status_t                   status;
  } heap_rsp_t;

  logic clk;
  logic rst;

  mhdr_req_if req_if ();
  mhdr_rsp_if rsp_if ();

  max_heap_delete_root_top uut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  // Requests waiting to be driven, and results the heap still owes us.
  heap_req_t req_items[$];
  heap_rsp_t heap_results[$];

  // Shadow of the heap contents used for prediction.
  data_t heap_mem [CAPACITY];
  int    heap_cnt;

  // Generator bookkeeping: occupancy and the lowest value appended in order.
  int     gen_cnt;
  longint floor_val;

  int acc_cnt;
  int errors;
  int n_append;
  int n_delete;
  int n_empty;
  int n_full;
  int max_fill;
  logic req_fire;

  int  hold_left;
  bit  hold_done;
  bit  pause_done;

  always #5 clk = ~clk;

  // Apply one request to the shadow heap and return the response it causes.
  function automatic void heap_apply(input req_type_t op,
                                     input logic signed [VALUE_W-1:0] val,
                                     output heap_rsp_t r);
    int    pos;
    int    lc;
    int    rc;
    int    best;
    bit    done;
    data_t tmp;
    logic signed [VALUE_W-1:0] root;

    r.removed = '0;
    r.status  = ST_OK;
    if (op == REQ_APPEND) begin
      if (heap_cnt >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        tmp = val;
        heap_mem[heap_cnt] = tmp;
        heap_cnt++;
      end
    end else if (heap_cnt == 0) begin
      r.status = ST_EMPTY;
    end else begin
      root      = heap_mem[0];
      r.removed = root;
      heap_mem[0] = heap_mem[heap_cnt-1];
      heap_cnt--;
      // Sift the moved entry down; ties keep the parent, and the left child wins
      // a tie between the children.
      pos  = 0;
      done = 0;
      while (!done && pos < heap_cnt) begin
        best = pos;
        lc   = 2 * pos + 1;
        rc   = 2 * pos + 2;
        if (lc < heap_cnt && heap_mem[lc] > heap_mem[best]) best = lc;
        if (rc < heap_cnt && heap_mem[rc] > heap_mem[best]) best = rc;
        if (best == pos) begin
          done = 1;
        end else begin
          tmp            = heap_mem[pos];
          heap_mem[pos]  = heap_mem[best];
          heap_mem[best] = tmp;
          pos            = best;
        end
      end
    end
    r.count = REM_W'(heap_cnt);
  endfunction

  // Pick a fresh starting point for an ordered fill of an empty heap.
  function automatic void restart_floor();
    if ($urandom_range(0, 2) == 0) begin
      floor_val = VAL_MAX;
    end else begin
      floor_val = longint'($signed($urandom));
    end
  endfunction

  // Next value no larger than any value it returned since the last restart of the floor.
  function automatic logic signed [VALUE_W-1:0] ordered_value();
    longint step;

    case ($urandom_range(0, 3))
      0: step = 0;
      1: step = longint'($urandom_range(1, 16));
      2: step = longint'($urandom_range(1, 1 << 20));
      default: step = longint'($urandom_range(1, 32'h3fff_ffff));
    endcase
    floor_val = floor_val - step;
    if (floor_val < VAL_MIN) floor_val = VAL_MIN;
    return VALUE_W'(floor_val);
  endfunction

  task automatic add_req(input req_type_t op, input logic signed [VALUE_W-1:0] v);
    heap_req_t it;

    it.op  = op;
    it.val = v;
    req_items.push_back(it);
    if (op == REQ_APPEND) begin
      if (gen_cnt < CAPACITY) gen_cnt++;
    end else if (gen_cnt > 0) begin
      gen_cnt--;
      if (gen_cnt == 0) restart_floor();
    end
  endtask

  // Request driver: a word is held until taken, then the next one is offered.
  always @(negedge clk) begin : drive_req
    heap_req_t nxt;
    int        phase;
    bit        gap;
    bit        paused;

    if (rst) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_fire) begin
      phase = (acc_cnt / PHASE_LEN) % 4;
      gap   = (phase == 1) ? ($urandom_range(0, 99) < 58) :
              (phase == 3) ? ($urandom_range(0, 99) < 16) : 1'b0;
      // Stop once, until every outstanding result has come back.
      if (!pause_done && acc_cnt >= PAUSE_AT && heap_results.size() == 0) begin
        pause_done = 1;
      end
      paused = !pause_done && acc_cnt >= PAUSE_AT;
      if (req_items.size() != 0 && !gap && !paused) begin
        nxt = req_items.pop_front();
        req_if.valid    <= 1'b1;
        req_if.req_type <= nxt.op;
        req_if.value    <= nxt.val;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Response ready: random stalls by phase, plus one long hold-off.
  always @(negedge clk) begin : drive_rsp_ready
    int phase;

    phase = (acc_cnt / PHASE_LEN) % 4;
    if (!hold_done && acc_cnt >= HOLD_AT) begin
      hold_done = 1;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_if.ready <= 1'b0;
    end else if (phase == 2) begin
      rsp_if.ready <= ($urandom_range(0, 99) >= 58);
    end else if (phase == 3) begin
      rsp_if.ready <= ($urandom_range(0, 99) >= 16);
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  // Predict on every accepted request and check every accepted response.
  always @(posedge clk) begin : watch
    heap_rsp_t want;

    if (rst) begin
      req_fire <= 1'b0;
    end else begin
      req_fire <= req_if.valid && req_if.ready;
      if (req_if.valid && req_if.ready) begin
        heap_apply(req_type_t'(req_if.req_type), req_if.value, want);
        heap_results.push_back(want);
        acc_cnt++;
        if (heap_cnt > max_fill) max_fill = heap_cnt;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (heap_results.size() == 0) begin
          $error("response word with no request outstanding: removed_value %0d",
                 rsp_if.removed_value);
          errors++;
        end else begin
          want = heap_results.pop_front();
          if (rsp_if.removed_value !== want.removed) begin
            $error("removed_value: expected %0d, actual %0d", want.removed,
                   rsp_if.removed_value);
            errors++;
          end
          if (rsp_if.remaining_count !== want.count) begin
            $error("remaining_count: expected %0d, actual %0d", want.count,
                   rsp_if.remaining_count);
            errors++;
          end
          if (rsp_if.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp_if.status);
            errors++;
          end
          case (want.status)
            ST_EMPTY: n_empty++;
            ST_FULL:  n_full++;
            default: begin
              if (want.removed === '0 && want.count > 0 && n_append < 0) n_append++;
            end
          endcase
        end
      end
    end
  end

  // Count accepted operations by kind for the summary.
  always @(posedge clk) begin
    if (!rst && req_if.valid && req_if.ready) begin
      if (req_if.req_type == REQ_APPEND) n_append++;
      else n_delete++;
    end
  end

  // Hard stop in case the heap hangs.
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int base_n;
    int n;
    int mode;
    bit first;

    clk             = 1'b0;
    rst             = 1'b1;
    req_if.valid    = 1'b0;
    req_if.req_type = REQ_APPEND;
    req_if.value    = '0;
    rsp_if.ready    = 1'b0;
    req_fire        = 1'b0;
    heap_cnt        = 0;
    gen_cnt         = 0;
    acc_cnt         = 0;
    errors          = 0;
    n_append        = 0;
    n_delete        = 0;
    n_empty         = 0;
    n_full          = 0;
    max_fill        = 0;
    hold_left       = 0;
    hold_done       = 0;
    pause_done      = 0;
    restart_floor();

    // Directed: empty delete, value extremes, ties with the parent and between
    // children, and draining past empty.
    add_req(REQ_DELETE, 32'sh1234_5678);
    add_req(REQ_APPEND, 32'sh7fff_ffff);
    add_req(REQ_APPEND, 32'sh0);
    add_req(REQ_APPEND, -32'sh1);
    add_req(REQ_APPEND, 32'sh8000_0000);
    add_req(REQ_APPEND, 32'sh0);
    add_req(REQ_APPEND, -32'sh1);
    repeat (7) add_req(REQ_DELETE, $urandom);
    add_req(REQ_APPEND, 32'sd100);
    add_req(REQ_APPEND, 32'sd50);
    add_req(REQ_APPEND, 32'sd50);
    add_req(REQ_APPEND, 32'sd10);
    repeat (4) add_req(REQ_DELETE, $urandom);
    restart_floor();

    // Random: mostly ordered fills and drains, some free mixing and noise.
    base_n = req_items.size();
    first  = 1;
    while (req_items.size() < base_n + N_RANDOM) begin
      mode  = first ? 0 : $urandom_range(0, 9);
      first = 0;
      if (mode <= 1) begin
        while (gen_cnt < CAPACITY) add_req(REQ_APPEND, ordered_value());
        repeat ($urandom_range(1, 3)) add_req(REQ_APPEND, ordered_value());
      end else if (mode <= 4) begin
        repeat ($urandom_range(1, 20)) add_req(REQ_APPEND, ordered_value());
      end else if (mode <= 6) begin
        n = (gen_cnt == 0) ? 1 : $urandom_range(1, gen_cnt);
        if ($urandom_range(0, 3) == 0) n = gen_cnt + $urandom_range(1, 2);
        repeat (n) add_req(REQ_DELETE, $urandom);
      end else if (mode <= 8) begin
        repeat (12) begin
          if ($urandom_range(0, 1) == 0) add_req(REQ_APPEND, ordered_value());
          else add_req(REQ_DELETE, $urandom);
        end
      end else begin
        repeat (4) begin
          add_req($urandom_range(0, 1) ? REQ_DELETE : REQ_APPEND, $urandom);
        end
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait until all words are taken and answered, then let the block settle.
    while (req_items.size() != 0 || req_if.valid) @(negedge clk);
    while (heap_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);

    $display("Covered %0d appends and %0d deletes, heap filled up to %0d entries.",
             n_append, n_delete, max_fill);
    $display("Saw %0d deletes on an empty heap and %0d appends to a full heap.",
             n_empty, n_full);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: max_heap_delete_root_top.f
+incdir+src
src/mhdr_pkg.sv
src/mhdr_req_if.sv
src/mhdr_rsp_if.sv
src/mhdr_ram.sv
src/max_heap_delete_root_top.sv
tb/tb_top.sv
